@@ rtl/swfr_pkg.sv @@
// ----------------------------------------------------------------------------
// swfr_pkg
// Shared types and constants for the stop-and-wait frame receiver.
// ----------------------------------------------------------------------------
package swfr_pkg;

  localparam logic [7:0] EOP_BASE   = 8'h30;
  localparam logic [7:0] EOP_LAST   = EOP_BASE + 8'd1;
  localparam logic [8:0] CHECK_TAIL = 9'd3;
  localparam logic [7:0] MIN_FRAME  = 8'd6;
  localparam logic [7:0] HDR_END    = 8'd4;

  typedef enum logic [1:0] {
    ST_BAD  = 2'd0,
    ST_DUP  = 2'd1,
    ST_GOOD = 2'd2
  } frame_status_t;

  typedef struct packed {
    logic          payload_valid;
    logic [7:0]    payload_byte;
    logic          frame_done;
    frame_status_t frame_status;
    logic [15:0]   seq_number;
    logic          end_of_packet;
    logic          ack_send;
  } result_t;

endpackage

@@ rtl/stop_and_wait_frame_receiver_core.sv @@
// ----------------------------------------------------------------------------
// stop_and_wait_frame_receiver_core
// Receiver for length-prefixed stop-and-wait frames with a 16-bit XOR check.
// ----------------------------------------------------------------------------
// One stream byte is accepted per clock cycle. Each accepted transaction
// updates the frame counters and check fold, and any
// result it causes (a tentative payload byte or a frame verdict) appears
// in the output register on the next cycle. in_ready stays high unless that
// output register holds a result while out_ready is low, so sustained
// throughput is one byte per cycle whenever the result side keeps up.
module stop_and_wait_frame_receiver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic        out_frame_done,
  output logic [1:0]  out_frame_status,
  output logic [15:0] out_seq_number,
  output logic        out_end_of_packet,
  output logic        out_ack_send
);
  import swfr_pkg::*;

  logic    acc;
  logic    space;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_ready = space;
  assign acc      = in_valid && space;

  swfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .data_byte (in_data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  swfr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_res  (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .space     (space),
    .out_res   (out_res)
  );

  assign out_payload_valid = out_res.payload_valid;
  assign out_payload_byte  = out_res.payload_byte;
  assign out_frame_done    = out_res.frame_done;
  assign out_frame_status  = out_res.frame_status;
  assign out_seq_number    = out_res.seq_number;
  assign out_end_of_packet = out_res.end_of_packet;
  assign out_ack_send      = out_res.ack_send;

endmodule

@@ rtl/swfr_parser.sv @@
// ----------------------------------------------------------------------------
// swfr_parser
// Frame state tracking, check fold and verdict logic, one byte per cycle while acc is high.
// ----------------------------------------------------------------------------
module swfr_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [7:0]       data_byte,
  output logic             res_valid,
  output swfr_pkg::result_t res
);
  import swfr_pkg::*;

  logic        await_r, await_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  even_r, even_nxt;
  logic [7:0]  odd_r, odd_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic        eop_r, eop_nxt;
  logic [7:0]  chk_r, chk_nxt;
  logic [15:0] exp_r, exp_nxt;

  logic [8:0]  pos_ext;
  logic [8:0]  len_ext;
  logic [15:0] calc;
  logic [15:0] recv;

  assign pos_ext = {1'b0, pos_r};
  assign len_ext = {1'b0, len_r};
  assign calc    = {odd_r, even_r};
  assign recv    = {data_byte, chk_r};

  always_comb begin
    await_nxt = await_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    even_nxt  = even_r;
    odd_nxt   = odd_r;
    seq_nxt   = seq_r;
    eop_nxt   = eop_r;
    chk_nxt   = chk_r;
    exp_nxt   = exp_r;
    res_valid = 1'b0;
    res       = '0;
    if (acc) begin
      if (await_r) begin
        len_nxt  = data_byte;
        pos_nxt  = '0;
        even_nxt = '0;
        odd_nxt  = '0;
        seq_nxt  = '0;
        eop_nxt  = 1'b0;
        chk_nxt  = '0;
        if (data_byte == 8'd0) begin
          res_valid        = 1'b1;
          res.frame_done   = 1'b1;
          res.frame_status = ST_BAD;
        end else begin
          await_nxt = 1'b0;
        end
      end else begin
        // words at even positions below len-3 enter the fold
        if (({1'b0, pos_r[7:1], 1'b0} + CHECK_TAIL) < len_ext) begin
          if (pos_r[0]) begin
            odd_nxt = odd_r ^ data_byte;
          end else begin
            even_nxt = even_r ^ data_byte;
          end
        end
        if (pos_r == 8'd0) begin
          seq_nxt[7:0] = data_byte;
        end else if (pos_r == 8'd1) begin
          seq_nxt[15:8] = data_byte;
        end else if (pos_r == 8'd3) begin
          eop_nxt = (data_byte == EOP_LAST);
        end
        if ((len_r >= 8'd2) && (pos_r == (len_r - 8'd2))) begin
          chk_nxt = data_byte;
        end
        if ((pos_ext + 9'd1) == len_ext) begin
          await_nxt         = 1'b1;
          res_valid         = 1'b1;
          res.frame_done    = 1'b1;
          res.frame_status  = ST_BAD;
          res.seq_number    = seq_nxt;
          res.end_of_packet = eop_nxt;
          if (len_r >= MIN_FRAME) begin
            if (calc != recv) begin
              res.frame_status = ST_BAD;
            end else if (seq_nxt != exp_r) begin
              res.frame_status = ST_DUP;
              res.ack_send     = 1'b1;
            end else begin
              res.frame_status = ST_GOOD;
              res.ack_send     = 1'b1;
              exp_nxt          = exp_r + 16'd1;
            end
          end
        end else begin
          pos_nxt = pos_r + 8'd1;
          if ((len_r >= MIN_FRAME) && (pos_r >= HDR_END) &&
              ((pos_ext + CHECK_TAIL) <= len_ext)) begin
            res_valid         = 1'b1;
            res.payload_valid = 1'b1;
            res.payload_byte  = data_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_r <= 1'b1;
      len_r   <= '0;
      pos_r   <= '0;
      even_r  <= '0;
      odd_r   <= '0;
      seq_r   <= '0;
      eop_r   <= 1'b0;
      chk_r   <= '0;
      exp_r   <= '0;
    end else begin
      await_r <= await_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      even_r  <= even_nxt;
      odd_r   <= odd_nxt;
      seq_r   <= seq_nxt;
      eop_r   <= eop_nxt;
      chk_r   <= chk_nxt;
      exp_r   <= exp_nxt;
    end
  end

`ifndef SYNTH
  a_done_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.frame_done) |=> await_r)
    else $error("length byte not expected after verdict");

  a_good_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.frame_done && (res.frame_status == ST_GOOD))
      |=> (exp_r == $past(exp_r) + 16'd1))
    else $error("expected sequence did not advance");

  a_ack_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.ack_send) |-> (res.frame_status != ST_BAD))
    else $error("ack on bad frame");

  a_payload_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.payload_valid) |-> (!await_r && !res.frame_done))
    else $error("payload outside frame body");
`endif

endmodule

@@ rtl/swfr_out_reg.sv @@
// ----------------------------------------------------------------------------
// swfr_out_reg
// Result register between the parser and the output channel.
// ----------------------------------------------------------------------------
module swfr_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  swfr_pkg::result_t load_res,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              space,
  output swfr_pkg::result_t out_res
);
  import swfr_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;

  assign space = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = load_res;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |-> !load)
    else $error("pending result overwritten");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (valid_r && (res_r == $past(load_res))))
    else $error("loaded result not presented");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_ready && !load) |=> !valid_r)
    else $error("taken result still valid");
`endif

endmodule
